### sv/affine_voxel_lookup_top_assert.svh
// Assertion macros for the port-level checker.
`ifndef AFFINE_VOXEL_LOOKUP_TOP_ASSERT_SVH
`define AFFINE_VOXEL_LOOKUP_TOP_ASSERT_SVH

// Implication checked only out of reset.
`define AVL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked only out of reset.
`define AVL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Implication checked at every edge, reset included.
`define AVL_ASSERT_ALL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

### sv/avl_pkg.sv
// Types and constants of the affine voxel lookup.
package avl_pkg;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_LOAD  = 2'd2,
		MODE_NONE  = 2'd3
	} avl_mode_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 63;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT0  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT1  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT2  = 3'd6;

	localparam int ROW_W     = 60;
	localparam int COEF_W    = 20;
	localparam int TRANS_W   = 21;
	localparam int TRANS_ALL = 63;
	localparam int EXT_W     = 7;
	localparam int COORD_W   = 17;
	localparam int LOAD_W    = 6;
	localparam int SAMP_W    = 16;
	localparam int PROD_W    = 37;
	localparam int SUM_W     = 40;
	localparam int FRAC_BITS = 22;
	localparam int TRANS_SH  = 12;
	localparam int IX_W      = 20;
	localparam int LIM_W     = 10;

	typedef struct packed {
		logic [ROW_W-1:0]     row0;
		logic [ROW_W-1:0]     row1;
		logic [ROW_W-1:0]     row2;
		logic [TRANS_ALL-1:0] trans;
		logic [EXT_W-1:0]     ext0;
		logic [EXT_W-1:0]     ext1;
		logic [EXT_W-1:0]     ext2;
	} avl_cfg_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic hit;
	} avl_ctl_t;

	typedef struct packed {
		logic clearing;
	} avl_stat_t;

endpackage

### sv/avl_if.sv
// Valid/ready channel interfaces for items and results.
interface avl_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic signed [16:0]        coord_r;
	logic signed [16:0]        coord_a;
	logic signed [16:0]        coord_s;
	logic [5:0]                load_first;
	logic [5:0]                load_second;
	logic [5:0]                load_third;
	logic signed [15:0]        sample_in;

	modport source(output valid, mode, coord_r, coord_a, coord_s, load_first, load_second,
		load_third, sample_in, input ready);
	modport sink(input valid, mode, coord_r, coord_a, coord_s, load_first, load_second,
		load_third, sample_in, output ready);
endinterface

interface avl_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               inside_res;

	modport source(output valid, sample_out, inside_res, input ready);
	modport sink(input valid, sample_out, inside_res, output ready);
endinterface

### sv/avl_front.sv
// Front end: affine transform, bounds check and address forming.
module avl_front #(
	parameter int SIDE = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	avl_in_if.sink                                 in_ch,
	input  avl_pkg::avl_cfg_t                      cfg,
	input  avl_pkg::avl_stat_t                     stat,
	input  logic                                   q_full,
	output logic                                   push,
	output avl_pkg::avl_ctl_t                      ctl,
	output logic [$clog2(SIDE*SIDE*SIDE)-1:0]      addr,
	output logic [avl_pkg::SAMP_W-1:0]             wdata
);
	localparam int ADDR_W = $clog2(SIDE*SIDE*SIDE);
	localparam int IXU_W  = $clog2(SIDE);

	logic adv;

	logic                                     v_s1, v_s2, v_s3;
	avl_pkg::avl_mode_t                       mode_s1, mode_s2, mode_s3;
	logic [avl_pkg::LOAD_W-1:0]               ld_s1 [3];
	logic [avl_pkg::LOAD_W-1:0]               ld_s2 [3];
	logic [avl_pkg::SAMP_W-1:0]               samp_s1, samp_s2, samp_s3;
	logic signed [avl_pkg::PROD_W-1:0]        prod_s1 [3][3];
	logic signed [avl_pkg::SUM_W-1:0]         sum_s2 [3];
	logic signed [avl_pkg::IX_W-1:0]          idx_s3 [3];

	logic [avl_pkg::ROW_W-1:0]                rows [3];
	logic signed [avl_pkg::COORD_W-1:0]       crd [3];
	logic signed [avl_pkg::SUM_W-1:0]         tsh [3];
	logic signed [avl_pkg::SUM_W-1:0]         bias [3];
	logic signed [avl_pkg::SUM_W-1:0]         rnd [3];
	logic [avl_pkg::EXT_W-1:0]                ext [3];
	logic [avl_pkg::LIM_W-1:0]                lim [3];
	logic [2:0]                               inr;
	logic [IXU_W-1:0]                         iu [3];
	logic                                     hit;

	assign rows[0] = cfg.row0;
	assign rows[1] = cfg.row1;
	assign rows[2] = cfg.row2;
	assign ext[0]  = cfg.ext0;
	assign ext[1]  = cfg.ext1;
	assign ext[2]  = cfg.ext2;
	assign crd[0]  = in_ch.coord_r;
	assign crd[1]  = in_ch.coord_a;
	assign crd[2]  = in_ch.coord_s;

	// whole pipe holds while the last stage waits on a full queue
	assign adv         = !(v_s3 && q_full);
	assign push        = v_s3 && !q_full;
	assign in_ch.ready = adv && !stat.clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid && in_ch.ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: nine products, Q4.16 x Q11.6
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= avl_pkg::avl_mode_t'(in_ch.mode);
			ld_s1[0] <= in_ch.load_first;
			ld_s1[1] <= in_ch.load_second;
			ld_s1[2] <= in_ch.load_third;
			samp_s1 <= in_ch.sample_in;
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s1[k][i] <= $signed(rows[k][avl_pkg::COEF_W*i +: avl_pkg::COEF_W])
						* crd[i];
				end
			end
		end
	end

	// stage 2: row sums with translation at Q.22
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tsh[k] = avl_pkg::SUM_W'($signed(cfg.trans[avl_pkg::TRANS_W*k +: avl_pkg::TRANS_W]))
				<<< avl_pkg::TRANS_SH;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_s1;
			ld_s2   <= ld_s1;
			samp_s2 <= samp_s1;
			for (int k = 0; k < 3; k++) begin
				sum_s2[k] <= tsh[k] + prod_s1[k][0] + prod_s1[k][1] + prod_s1[k][2];
			end
		end
	end

	// stage 3: truncate toward zero, minus one; direct indices for load
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			bias[k] = sum_s2[k][avl_pkg::SUM_W-1] ?
				avl_pkg::SUM_W'((64'd1 << avl_pkg::FRAC_BITS) - 64'd1) : '0;
			rnd[k]  = sum_s2[k] + bias[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3 <= mode_s2;
			samp_s3 <= samp_s2;
			for (int k = 0; k < 3; k++) begin
				if (mode_s2 == avl_pkg::MODE_LOAD) begin
					idx_s3[k] <= $signed({{(avl_pkg::IX_W-avl_pkg::LOAD_W){1'b0}}, ld_s2[k]});
				end else begin
					idx_s3[k] <= avl_pkg::IX_W'(rnd[k] >>> avl_pkg::FRAC_BITS)
						- avl_pkg::IX_W'(1);
				end
			end
		end
	end

	// bounds against extents saturated at SIDE
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lim[k] = ({3'b000, ext[k]} > avl_pkg::LIM_W'(SIDE)) ? avl_pkg::LIM_W'(SIDE)
				: {3'b000, ext[k]};
			inr[k] = !idx_s3[k][avl_pkg::IX_W-1] &&
				(idx_s3[k] < $signed({{(avl_pkg::IX_W-avl_pkg::LIM_W){1'b0}}, lim[k]}));
			iu[k]  = idx_s3[k][IXU_W-1:0];
		end
		hit = (&inr) && (mode_s3 != avl_pkg::MODE_NONE);
	end

	assign ctl.hit = hit;
	assign ctl.rd  = hit && (mode_s3 == avl_pkg::MODE_READ);
	assign ctl.wr  = hit && (mode_s3 == avl_pkg::MODE_WRITE || mode_s3 == avl_pkg::MODE_LOAD);
	assign addr    = (ADDR_W'(iu[0]) * ADDR_W'(SIDE) + ADDR_W'(iu[1])) * ADDR_W'(SIDE)
		+ ADDR_W'(iu[2]);
	assign wdata   = samp_s3;

endmodule

### sv/avl_fifo.sv
// Short FIFO between front and back ends.
module avl_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic         nonempty,
	output logic [W-1:0] dout
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign dout     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

### sv/avl_back.sv
// Back end: voxel memory, clearing sweep and result register.
module avl_back #(
	parameter int SIDE        = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  avl_pkg::avl_ctl_t                  ctl,
	input  logic [$clog2(SIDE*SIDE*SIDE)-1:0]  addr,
	input  logic [avl_pkg::SAMP_W-1:0]         wdata,
	output logic                               pop,
	output avl_pkg::avl_stat_t                 stat,
	avl_out_if.source                          out_ch
);
	localparam int DEPTH  = SIDE * SIDE * SIDE;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	logic [SAMPLE_BITS-1:0] rdata_q;
	logic [ADDR_W-1:0]      clr_q;
	logic                   clearing_q;
	logic                   out_valid_q, rd_q, hit_q;

	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_wa;
	logic [SAMPLE_BITS-1:0] mem_wd;
	logic signed [31:0]     wide_in, wide_rd;

	assign stat.clearing = clearing_q;
	assign pop = q_valid && !clearing_q && (!out_valid_q || out_ch.ready);

	assign wide_in = 32'($signed(wdata));
	assign wide_rd = 32'($signed(rdata_q));
	assign mem_we  = clearing_q || (pop && ctl.wr);
	assign mem_wa  = clearing_q ? clr_q : addr;
	assign mem_wd  = clearing_q ? '0 : wide_in[SAMPLE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (pop) begin
			rdata_q <= mem[addr];
			rd_q    <= ctl.rd;
			hit_q   <= ctl.hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.inside_res = hit_q;
	assign out_ch.sample_out = rd_q ? wide_rd[avl_pkg::SAMP_W-1:0] : '0;

endmodule

### sv/affine_voxel_lookup_top.sv
// Top level of the affine voxel lookup: config registers, front, queue, back.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------------
//  in_ch    | in  | valid/ready    | mode, coord_r/a/s, load_first/second/third,
//           |     |                | sample_in
//  out_ch   | out | valid/ready    | sample_out, inside_res
//  cfg      | in  | cfg_we only    | cfg_index, cfg_data
//
// One item per cycle sustained while out_ch takes results; each result passes
// the three front stages, the queue and the result register. After reset the
// voxel memory is swept to zero, one entry a cycle; in_ch.ready stays low
// until the sweep ends. A stalled out_ch holds its result; the four-entry
// queue and the front pipe keep taking items until both are full.
module affine_voxel_lookup_top #(
	parameter int SIDE        = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	avl_in_if.sink                            in_ch,
	avl_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [avl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [avl_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int ADDR_W = $clog2(SIDE*SIDE*SIDE);
	localparam int CTL_W  = $bits(avl_pkg::avl_ctl_t);
	localparam int Q_W    = CTL_W + ADDR_W + avl_pkg::SAMP_W;
	localparam int Q_DEPTH = 4;

	avl_pkg::avl_cfg_t  cfg_q;
	avl_pkg::avl_stat_t stat;

	logic                        push, q_full, q_nonempty, pop;
	avl_pkg::avl_ctl_t           f_ctl, b_ctl;
	logic [ADDR_W-1:0]           f_addr, b_addr;
	logic [avl_pkg::SAMP_W-1:0]  f_wdata, b_wdata;
	logic [Q_W-1:0]              q_din, q_dout;

	// configuration registers; out-of-range index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row0  <= '0;
			cfg_q.row1  <= '0;
			cfg_q.row2  <= '0;
			cfg_q.trans <= '0;
			cfg_q.ext0  <= 7'd64;
			cfg_q.ext1  <= 7'd64;
			cfg_q.ext2  <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				avl_pkg::CFG_ROW0:  cfg_q.row0  <= cfg_data[avl_pkg::ROW_W-1:0];
				avl_pkg::CFG_ROW1:  cfg_q.row1  <= cfg_data[avl_pkg::ROW_W-1:0];
				avl_pkg::CFG_ROW2:  cfg_q.row2  <= cfg_data[avl_pkg::ROW_W-1:0];
				avl_pkg::CFG_TRANS: cfg_q.trans <= cfg_data[avl_pkg::TRANS_ALL-1:0];
				avl_pkg::CFG_EXT0:  cfg_q.ext0  <= cfg_data[avl_pkg::EXT_W-1:0];
				avl_pkg::CFG_EXT1:  cfg_q.ext1  <= cfg_data[avl_pkg::EXT_W-1:0];
				avl_pkg::CFG_EXT2:  cfg_q.ext2  <= cfg_data[avl_pkg::EXT_W-1:0];
				default: ;
			endcase
		end
	end

	// front: three stages of affine math, classification at the queue input
	avl_front #(.SIDE(SIDE)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.stat   (stat),
		.q_full (q_full),
		.push   (push),
		.ctl    (f_ctl),
		.addr   (f_addr),
		.wdata  (f_wdata)
	);

	assign q_din = {f_ctl, f_addr, f_wdata};

	avl_fifo #(.W(Q_W), .DEPTH(Q_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (q_din),
		.full     (q_full),
		.pop      (pop),
		.nonempty (q_nonempty),
		.dout     (q_dout)
	);

	assign b_ctl   = avl_pkg::avl_ctl_t'(q_dout[Q_W-1 -: CTL_W]);
	assign b_addr  = q_dout[avl_pkg::SAMP_W +: ADDR_W];
	assign b_wdata = q_dout[avl_pkg::SAMP_W-1:0];

	// back: in-order memory access, so a write is seen by any later read
	avl_back #(.SIDE(SIDE), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_nonempty),
		.ctl     (b_ctl),
		.addr    (b_addr),
		.wdata   (b_wdata),
		.pop     (pop),
		.stat    (stat),
		.out_ch  (out_ch)
	);

endmodule

### sv/avl_chk.sv
// Port-level checker for the affine voxel lookup, bound to the top level.
`include "affine_voxel_lookup_top_assert.svh"

module avl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] sample_out,
	input logic        inside_res
);

	// stalled result holds
	`AVL_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(sample_out) && $stable(inside_res))

	// a miss never carries a sample
	`AVL_ASSERT_IMP(a_miss_zero, out_valid && !inside_res, sample_out == 16'd0)

	// memory sweep keeps the input closed right after reset
	`AVL_ASSERT_ALL(a_sweep_closed, $rose(arst_n), !in_ready)

	// nothing comes out before any item could have gone in
	`AVL_ASSERT_ALL(a_no_early_out, $rose(arst_n), !out_valid)

endmodule

bind affine_voxel_lookup_top avl_chk u_avl_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.sample_out (out_ch.sample_out),
	.inside_res (out_ch.inside_res)
);

### verif/avl_lookup_checker.sv
// Lookup predictor and result checker for the affine voxel lookup.
module avl_lookup_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	avl_in_if                               in_ch,
	avl_out_if                              out_ch,
	input  logic                            cfg_we,
	input  logic [avl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [avl_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              errors,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [avl_pkg::SAMP_W-1:0] sample;
		logic                              hit;
	} lookup_t;

	localparam int SIDE = 64;

	lookup_t                           lookups_due[$];
	logic signed [avl_pkg::SAMP_W-1:0] voxels[int];
	avl_pkg::avl_cfg_t                 regs;

	function automatic longint axis_index(logic [avl_pkg::ROW_W-1:0] row, int k,
			longint cr, longint ca, longint cs);
		longint acc;
		longint q;
		acc = longint'($signed(regs.trans[avl_pkg::TRANS_W*k +: avl_pkg::TRANS_W])) * 4096;
		acc += longint'($signed(row[19:0])) * cr;
		acc += longint'($signed(row[39:20])) * ca;
		acc += longint'($signed(row[59:40])) * cs;
		// truncate toward zero, not floor
		if (acc < 0)
			q = -((-acc) >>> avl_pkg::FRAC_BITS);
		else
			q = acc >>> avl_pkg::FRAC_BITS;
		return q - 1;
	endfunction

	function automatic longint clamp_ext(logic [avl_pkg::EXT_W-1:0] e);
		return (e > SIDE) ? SIDE : longint'(e);
	endfunction

	function automatic lookup_t predict_lookup(avl_pkg::avl_mode_t m, longint cr, longint ca,
			longint cs, int l0, int l1, int l2, logic signed [avl_pkg::SAMP_W-1:0] smp);
		lookup_t r;
		longint ix[3];
		int addr;
		r.sample = '0;
		r.hit = 1'b0;
		if (m == avl_pkg::MODE_NONE)
			return r;
		if (m == avl_pkg::MODE_LOAD) begin
			ix[0] = l0; ix[1] = l1; ix[2] = l2;
		end else begin
			ix[0] = axis_index(regs.row0, 0, cr, ca, cs);
			ix[1] = axis_index(regs.row1, 1, cr, ca, cs);
			ix[2] = axis_index(regs.row2, 2, cr, ca, cs);
		end
		r.hit = ix[0] >= 0 && ix[0] < clamp_ext(regs.ext0) &&
			ix[1] >= 0 && ix[1] < clamp_ext(regs.ext1) &&
			ix[2] >= 0 && ix[2] < clamp_ext(regs.ext2);
		if (r.hit) begin
			addr = int'((ix[0] * SIDE + ix[1]) * SIDE + ix[2]);
			if (m == avl_pkg::MODE_READ)
				r.sample = voxels.exists(addr) ? voxels[addr] : '0;
			else
				voxels[addr] = smp;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			lookups_due.delete();
			voxels.delete();
			regs <= '{row0: '0, row1: '0, row2: '0, trans: '0, ext0: 7'd64, ext1: 7'd64,
				ext2: 7'd64};
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				avl_pkg::CFG_ROW0:  regs.row0  <= cfg_data[avl_pkg::ROW_W-1:0];
				avl_pkg::CFG_ROW1:  regs.row1  <= cfg_data[avl_pkg::ROW_W-1:0];
				avl_pkg::CFG_ROW2:  regs.row2  <= cfg_data[avl_pkg::ROW_W-1:0];
				avl_pkg::CFG_TRANS: regs.trans <= cfg_data[avl_pkg::TRANS_ALL-1:0];
				avl_pkg::CFG_EXT0:  regs.ext0  <= cfg_data[avl_pkg::EXT_W-1:0];
				avl_pkg::CFG_EXT1:  regs.ext1  <= cfg_data[avl_pkg::EXT_W-1:0];
				avl_pkg::CFG_EXT2:  regs.ext2  <= cfg_data[avl_pkg::EXT_W-1:0];
				default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (lookups_due.size() == 0) begin
					$display("%0t: result with none expected: sample_out %0d inside_res %0b",
						$time, out_ch.sample_out, out_ch.inside_res);
					errors <= errors + 1;
				end else begin
					want = lookups_due.pop_front();
					if (want.sample !== out_ch.sample_out || want.hit !== out_ch.inside_res) begin
						$display("%0t: mismatch: expected sample_out %0d inside_res %0b, got %0d %0b",
							$time, want.sample, want.hit, out_ch.sample_out, out_ch.inside_res);
						errors <= errors + 1;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				lookups_due.push_back(predict_lookup(avl_pkg::avl_mode_t'(in_ch.mode),
					longint'(in_ch.coord_r), longint'(in_ch.coord_a), longint'(in_ch.coord_s),
					int'(in_ch.load_first), int'(in_ch.load_second), int'(in_ch.load_third),
					in_ch.sample_in));
		end
	end

	assign pending = lookups_due.size();
endmodule

### verif/tb_top.sv
// Testbench top: clock, reset, stimulus phases and the verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint LIMIT = 1_500_000;	// covers the memory sweep, the rest is slack
	localparam int     ONE   = 65536;		// 1.0 in Q4.16

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [avl_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [avl_pkg::CFG_DATA_W-1:0] cfg_data;
	int errors;
	int pending;
	int items_sent;
	longint cycles = 0;
	bit held;
	int stall_left;

	avl_in_if  in_ch();
	avl_out_if out_ch();

	affine_voxel_lookup_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	avl_lookup_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: random stalls, plus one long hold-off mid-run so the
	// block backs up and drops in_ch.ready
	initial begin
		out_ch.ready <= 1'b0;
		held = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (!held && items_sent >= 300) begin
				held = 1;
				out_ch.ready <= 1'b0;
				repeat (80) @(posedge clk);
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// one transfer; called and returning at a rising edge
	task automatic send_item(avl_pkg::avl_mode_t m, int cr, int ca, int cs, int l0, int l1,
			int l2, int smp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.mode        <= m;
		in_ch.coord_r     <= 17'(cr);
		in_ch.coord_a     <= 17'(ca);
		in_ch.coord_s     <= 17'(cs);
		in_ch.load_first  <= 6'(l0);
		in_ch.load_second <= 6'(l1);
		in_ch.load_third  <= 6'(l2);
		in_ch.sample_in   <= 16'(smp);
		in_ch.valid       <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// drains results, then idles before any register write
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_regs(logic [59:0] r0, logic [59:0] r1, logic [59:0] r2,
			logic [62:0] tr, int e0, int e1, int e2);
		logic [avl_pkg::CFG_DATA_W-1:0] vals[7];
		vals = '{63'(r0), 63'(r1), 63'(r2), tr, 63'(e0), 63'(e1), 63'(e2)};
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= avl_pkg::CFG_IDX_W'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// index biased toward a small corner so reads find earlier writes
	function automatic int pick_index();
		return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 63);
	endfunction

	// coordinate that lands on index i under a unit coefficient
	function automatic int coord_for(int i);
		return 64 * (i + 1) + $urandom_range(0, 63);
	endfunction

	function automatic int any_coord();
		return int'($signed(17'($urandom)));
	endfunction

	task automatic random_items(int n);
		int p;
		avl_pkg::avl_mode_t m;
		for (int k = 0; k < n; k++) begin
			p = $urandom_range(0, 99);
			m = p < 30 ? avl_pkg::MODE_READ : p < 55 ? avl_pkg::MODE_WRITE :
				p < 95 ? avl_pkg::MODE_LOAD : avl_pkg::MODE_NONE;
			if ($urandom_range(0, 99) < 15)
				send_item(m, any_coord(), any_coord(), any_coord(), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63), int'($urandom));
			else
				send_item(m, coord_for(pick_index()), coord_for(pick_index()),
					coord_for(pick_index()), pick_index(), pick_index(), pick_index(),
					int'($urandom));
		end
	endtask

	// row picking one input axis with a near-unit weight, small cross terms
	function automatic logic [59:0] aimed_row(int axis, bit neg);
		logic [59:0] row;
		int v;
		for (int i = 0; i < 3; i++) begin
			if (i == axis)
				v = (neg ? -ONE : ONE) + $urandom_range(0, 4000) - 2000;
			else
				v = $urandom_range(0, 400) - 200;
			row[20*i +: 20] = 20'(v);
		end
		return row;
	endfunction

	function automatic logic [20:0] aimed_offset(bit neg);
		// a negative weight needs the volume shifted back into range
		return neg ? 21'(65 * 1024 + $urandom_range(0, 2048))
			: 21'($urandom_range(0, 4096) - 2048);
	endfunction

	function automatic logic [62:0] wide_random();
		return 63'({$urandom, $urandom});
	endfunction

	localparam logic [59:0] ID0 = 60'(ONE);
	localparam logic [59:0] ID1 = 60'(ONE) << 20;
	localparam logic [59:0] ID2 = 60'(ONE) << 40;

	initial begin
		bit n0, n1, n2;
		int ax;
		items_sent = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.mode <= avl_pkg::MODE_NONE;
		in_ch.coord_r <= '0;
		in_ch.coord_a <= '0;
		in_ch.coord_s <= '0;
		in_ch.load_first <= '0;
		in_ch.load_second <= '0;
		in_ch.load_third <= '0;
		in_ch.sample_in <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: zero affine puts every index at -1, so only loads hit
		send_item(avl_pkg::MODE_LOAD, 0, 0, 0, 0, 0, 0, 32767);
		send_item(avl_pkg::MODE_LOAD, 0, 0, 0, 63, 63, 63, -32768);
		send_item(avl_pkg::MODE_LOAD, 0, 0, 0, 1, 2, 3, -1);
		send_item(avl_pkg::MODE_READ, -65536, -65536, -65536, 0, 0, 0, 0);
		send_item(avl_pkg::MODE_WRITE, 65535, 65535, 65535, 0, 0, 0, 1234);
		send_item(avl_pkg::MODE_NONE, 65535, -65536, 0, 63, 63, 63, -32768);
		wait_idle();

		// unit affine: directed reads and writes at the corners
		program_regs(ID0, ID1, ID2, '0, 64, 64, 64);
		send_item(avl_pkg::MODE_READ, coord_for(0), coord_for(0), coord_for(0), 0, 0, 0, 0);
		send_item(avl_pkg::MODE_READ, coord_for(63), coord_for(63), coord_for(63), 0, 0, 0, 0);
		send_item(avl_pkg::MODE_READ, coord_for(1), coord_for(2), coord_for(3), 0, 0, 0, 0);
		send_item(avl_pkg::MODE_WRITE, coord_for(5), coord_for(6), coord_for(7), 0, 0, 0, -200);
		send_item(avl_pkg::MODE_READ, coord_for(5), coord_for(6), coord_for(7), 0, 0, 0, 0);
		send_item(avl_pkg::MODE_WRITE, 64 * 65, 64, 64, 0, 0, 0, 77);	// one past the end
		send_item(avl_pkg::MODE_READ, 63, 64, 64, 0, 0, 0, 0);			// truncates to -1
		send_item(avl_pkg::MODE_READ, -64, 64, 64, 0, 0, 0, 0);
		send_item(avl_pkg::MODE_NONE, coord_for(0), coord_for(0), coord_for(0), 0, 0, 0, 5);
		random_items(150);
		wait_idle();

		// permuted, possibly mirrored affine with small extents
		for (int ph = 0; ph < 2; ph++) begin
			ax = $urandom_range(0, 2);
			n0 = 1'($urandom_range(0, 1));
			n1 = 1'($urandom_range(0, 1));
			n2 = 1'($urandom_range(0, 1));
			program_regs(aimed_row(ax, n0), aimed_row((ax + 1) % 3, n1),
				aimed_row((ax + 2) % 3, n2),
				{aimed_offset(n2), aimed_offset(n1), aimed_offset(n0)},
				$urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64));
			random_items(90);
			wait_idle();
		end

		// zero extent misses everything; oversized extents clamp to the side
		program_regs(ID0, ID1, ID2, '0, 0, 127, 64);
		send_item(avl_pkg::MODE_LOAD, 0, 0, 0, 0, 0, 0, 9);
		send_item(avl_pkg::MODE_READ, coord_for(0), coord_for(0), coord_for(0), 0, 0, 0, 0);
		random_items(40);
		wait_idle();
		program_regs(ID0, ID1, ID2, '0, 127, 65, 1);
		send_item(avl_pkg::MODE_LOAD, 0, 0, 0, 63, 63, 0, 11);
		send_item(avl_pkg::MODE_LOAD, 0, 0, 0, 63, 63, 1, 12);
		send_item(avl_pkg::MODE_READ, coord_for(63), coord_for(63), coord_for(0), 0, 0, 0, 0);
		random_items(80);
		wait_idle();

		// raw random register bits, mostly misses
		program_regs(wide_random(), wide_random(), wide_random(), wide_random(),
			$urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
		random_items(60);
		wait_idle();
		program_regs(60'hFFF_FFFF_FFFF_FFFF, 60'hFFF_FFFF_FFFF_FFFF, 60'hFFF_FFFF_FFFF_FFFF,
			63'h7FFF_FFFF_FFFF_FFFF, 127, 127, 127);
		random_items(20);
		wait_idle();

		// back to the unit affine for the bulk of read-after-write traffic
		program_regs(ID0, ID1, ID2, {21'd512, 21'd0, -21'sd512}, 64, 64, 64);
		random_items(200);

		wait_idle();
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
